@@ rtl/servo_pulse_sequencer_with_keys_macros.svh @@
// Assertion macros for the servo pulse sequencer.
// Included by the top level; no other dependencies.
`ifndef SERVO_PULSE_SEQUENCER_WITH_KEYS_MACROS_SVH
`define SERVO_PULSE_SEQUENCER_WITH_KEYS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPSK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPSK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/spsk_pkg.sv @@
// Shared types and constants for the servo pulse sequencer.
// No dependencies.
package spsk_pkg;

    localparam int NUM_SERVOS = 5;
    localparam int WIDTH_W    = 16;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 2;

    typedef logic [WIDTH_W-1:0]                t_width;
    typedef t_width [NUM_SERVOS-1:0]           t_width_arr;
    typedef logic [1:0]                        t_opcode;
    typedef logic [7:0]                        t_char;
    typedef logic [PHASE_W-1:0]                t_phase;

    // Opcodes
    localparam t_opcode OP_TICK   = 2'd0;
    localparam t_opcode OP_KEY    = 2'd1;
    localparam t_opcode OP_SAFE   = 2'd2;
    localparam t_opcode OP_TOGGLE = 2'd3;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_FLOOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_CEIL   = 2'd2;

    localparam t_width RST_FRAME_PERIOD = 16'd62500;
    localparam t_width RST_WIDTH_FLOOR  = 16'd1562;
    localparam t_width RST_WIDTH_CEIL   = 16'd7812;
    localparam t_width RST_REST_GAP     = 16'd62500;
    localparam t_width WIDTH_STEP       = 16'd10;

    // Phase 5 is the rest gap; phases 0..4 start/pulse servos 1..5
    localparam t_phase PHASE_FIRST = 3'd0;
    localparam t_phase PHASE_REST  = 3'd5;

    localparam t_width_arr SAFE_WIDTHS = {16'd5802, 16'd2122, 16'd6157, 16'd6517, 16'd1992};

    // Key map, servo 1 at index 0
    localparam logic [NUM_SERVOS-1:0][7:0] UP_KEYS = {"t", "r", "e", "w", "q"};
    localparam logic [NUM_SERVOS-1:0][7:0] DN_KEYS = {"g", "f", "d", "s", "a"};
    localparam t_char CHAR_UP_A = "A";
    localparam t_char CHAR_UP_Z = "Z";
    localparam t_char CASE_OFS  = 8'd32;
    localparam int    DIGITAL_ONLY = 3;   // servos below this index ignore keys in analog mode

    typedef struct packed {
        logic [NUM_SERVOS-1:0] servo_lines;
        t_phase                frame_phase;
        logic                  analog_mode;
        logic                  position_changed;
        t_width_arr            widths;
    } t_result;

endpackage

@@ rtl/spsk_ifs.sv @@
// Valid/ready channel interfaces for the servo pulse sequencer items.
// Depends on spsk_pkg.
interface spsk_in_if;
    import spsk_pkg::*;
    logic    valid;
    logic    ready;
    t_opcode opcode;
    t_char   character;

    modport source (output valid, output opcode, output character, input ready);
    modport sink   (input valid, input opcode, input character, output ready);
endinterface

interface spsk_out_if;
    import spsk_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [NUM_SERVOS-1:0] servo_lines;
    t_phase                frame_phase;
    logic                  analog_mode;
    logic                  position_changed;
    t_width                width_one;
    t_width                width_two;
    t_width                width_three;
    t_width                width_four;
    t_width                width_five;

    modport source (output valid, output servo_lines, output frame_phase, output analog_mode,
                    output position_changed, output width_one, output width_two,
                    output width_three, output width_four, output width_five, input ready);
    modport sink   (input valid, input servo_lines, input frame_phase, input analog_mode,
                    input position_changed, input width_one, input width_two,
                    input width_three, input width_four, input width_five, output ready);
endinterface

@@ rtl/spsk_width_update.sv @@
// Pulse width update for key, safe-position and other items.
// Depends on spsk_pkg.
module spsk_width_update (
    input  spsk_pkg::t_opcode    i_opcode,
    input  spsk_pkg::t_char      i_character,
    input  logic                 i_mode,
    input  spsk_pkg::t_width     i_width_floor,
    input  spsk_pkg::t_width     i_width_ceil,
    input  spsk_pkg::t_width_arr i_widths,
    output spsk_pkg::t_width_arr o_widths,
    output logic                 o_changed
);
    import spsk_pkg::*;

    t_char                 lower;
    logic                  hit;
    logic [WIDTH_W:0]      up_sum;
    logic [WIDTH_W:0]      dn_floor;

    always_comb begin
        lower    = ((i_character >= CHAR_UP_A) && (i_character <= CHAR_UP_Z))
                   ? i_character + CASE_OFS : i_character;
        o_widths = i_widths;
        o_changed = 1'b0;
        hit      = 1'b0;
        up_sum   = '0;
        dn_floor = {1'b0, i_width_floor} + {1'b0, WIDTH_STEP};
        case (i_opcode)
            OP_SAFE: begin
                o_widths  = SAFE_WIDTHS;
                o_changed = 1'b1;
            end
            OP_KEY: begin
                for (int s = 0; s < NUM_SERVOS; s++) begin
                    up_sum = {1'b0, i_widths[s]} + {1'b0, WIDTH_STEP};
                    if (!hit && !((s < DIGITAL_ONLY) && i_mode)) begin
                        if (lower == UP_KEYS[s]) begin
                            hit = 1'b1;
                            if (up_sum <= {1'b0, i_width_ceil}) begin
                                o_widths[s] = up_sum[WIDTH_W-1:0];
                                o_changed   = 1'b1;
                            end
                        end else if (lower == DN_KEYS[s]) begin
                            hit = 1'b1;
                            if ({1'b0, i_widths[s]} >= dn_floor) begin
                                o_widths[s] = i_widths[s] - WIDTH_STEP;
                                o_changed   = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
                o_widths = i_widths;
            end
        endcase
    end

endmodule

@@ rtl/spsk_out_queue.sv @@
// Two-entry result queue: output register plus skid entry.
// Depends on spsk_pkg.
module spsk_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  spsk_pkg::t_result i_data,
    output logic              o_not_full,
    output logic              o_valid,
    input  logic              i_ready,
    output spsk_pkg::t_result o_data
);
    import spsk_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_result    r_head;
    t_result    r_skid;
    logic       pop;

    assign pop        = (r_cnt != 2'd0) && i_ready;
    assign o_valid    = (r_cnt != 2'd0);
    assign o_not_full = (r_cnt != 2'd2);
    assign o_data     = r_head;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && pop) begin
            if (r_cnt == 2'd1) begin
                r_head <= i_data;
            end else begin
                r_head <= r_skid;
                r_skid <= i_data;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_head <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end else if (pop) begin
            r_head <= r_skid;
        end
    end

endmodule

@@ rtl/servo_pulse_sequencer_with_keys.sv @@
// Top level of the five-channel servo pulse sequencer with key control.
// Depends on spsk_pkg, spsk_ifs, spsk_width_update, spsk_out_queue and the macros header.
//
// Usage:
//   i_in  carries items {opcode, character}: tick, received key, safe-position
//         button or analog-mode toggle. o_out returns one result item per input
//         item: servo line levels, frame phase, mode flag, change flag and the
//         five pulse widths after the item.
//   Config: i_cfg_we/i_cfg_index/i_cfg_data write frame_period (0), the width
//         floor (1) and the width ceiling (2); other indexes are dropped.
//   Output: a result is registered into the output queue when its item is accepted.
//   Throughput: one item per cycle while the output queue has room. The sequencer
//         state (timer, phase, widths, mode) updates in the accepting cycle through
//         16-bit compare/add logic; results sit in a two-entry output queue.
//   Stall: while o_out is stalled, i_in stays ready until the queue's skid
//         entry is used, so one extra item is taken before backpressure.
//   Reset: synchronous, active low. Lines low, frame phase shows the rest gap,
//         widths load the safe position, config returns to the 20 ms frame
//         defaults; the first tick starts servo 1.
`include "servo_pulse_sequencer_with_keys_macros.svh"

module servo_pulse_sequencer_with_keys (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    spsk_in_if.sink                            i_in,
    spsk_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [spsk_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  spsk_pkg::t_width                   i_cfg_data
);
    import spsk_pkg::*;

    // Config registers
    t_width r_frame_period;
    t_width r_width_floor;
    t_width r_width_ceil;

    // Sequencer state
    t_phase     r_phase;
    t_phase     n_phase;
    t_width     r_tick;
    t_width     n_tick;
    t_width     r_period_now;
    t_width     n_period_now;
    t_width     r_rest_gap;
    t_width     n_rest_gap;
    t_width_arr r_widths;
    t_width_arr n_widths;
    logic       r_mode;
    logic       n_mode;

    logic       accept;
    logic       q_not_full;
    logic       key_changed;
    t_width_arr key_widths;
    t_phase     active;
    t_result    result;
    t_result    q_data;

    assign i_in.ready = q_not_full;
    assign accept     = i_in.valid && q_not_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_period <= RST_FRAME_PERIOD;
            r_width_floor  <= RST_WIDTH_FLOOR;
            r_width_ceil   <= RST_WIDTH_CEIL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_PERIOD: r_frame_period <= i_cfg_data;
                CFG_WIDTH_FLOOR:  r_width_floor  <= i_cfg_data;
                CFG_WIDTH_CEIL:   r_width_ceil   <= i_cfg_data;
                default:          r_frame_period <= r_frame_period;
            endcase
        end
    end

    spsk_width_update u_width_update (
        .i_opcode      (i_in.opcode),
        .i_character   (i_in.character),
        .i_mode        (r_mode),
        .i_width_floor (r_width_floor),
        .i_width_ceil  (r_width_ceil),
        .i_widths      (r_widths),
        .o_widths      (key_widths),
        .o_changed     (key_changed)
    );

    // Next state for the accepted item
    always_comb begin
        n_phase      = r_phase;
        n_tick       = r_tick;
        n_period_now = r_period_now;
        n_rest_gap   = r_rest_gap;
        n_mode       = r_mode;
        n_widths     = key_widths;
        case (i_in.opcode)
            OP_TICK: begin
                if (r_tick == r_period_now) begin
                    // segment done: start the next servo pulse or the rest gap
                    n_tick = '0;
                    if (r_phase < PHASE_REST) begin
                        n_rest_gap   = r_frame_period - r_widths[r_phase];
                        n_period_now = r_widths[r_phase];
                        n_phase      = r_phase + 3'd1;
                    end else begin
                        n_period_now = r_rest_gap;
                        n_phase      = PHASE_FIRST;
                    end
                end else begin
                    n_tick = r_tick + 16'd1;
                end
            end
            OP_TOGGLE: begin
                n_mode = ~r_mode;
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PHASE_FIRST;
            r_tick       <= '0;
            r_period_now <= '0;
            r_rest_gap   <= RST_REST_GAP;
            r_widths     <= SAFE_WIDTHS;
            r_mode       <= 1'b0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_period_now <= n_period_now;
            r_rest_gap   <= n_rest_gap;
            r_widths     <= n_widths;
            r_mode       <= n_mode;
        end
    end

    // The running segment is the one before the next phase to start
    always_comb begin
        active = (n_phase == PHASE_FIRST) ? PHASE_REST : n_phase - 3'd1;
        result.servo_lines      = (active < PHASE_REST)
                                  ? NUM_SERVOS'(1) << active : '0;
        result.frame_phase      = active;
        result.analog_mode      = n_mode;
        result.position_changed = key_changed;
        result.widths           = n_widths;
    end

    spsk_out_queue u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_data     (result),
        .o_not_full (q_not_full),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_data     (q_data)
    );

    assign o_out.servo_lines      = q_data.servo_lines;
    assign o_out.frame_phase      = q_data.frame_phase;
    assign o_out.analog_mode      = q_data.analog_mode;
    assign o_out.position_changed = q_data.position_changed;
    assign o_out.width_one        = q_data.widths[0];
    assign o_out.width_two        = q_data.widths[1];
    assign o_out.width_three      = q_data.widths[2];
    assign o_out.width_four       = q_data.widths[3];
    assign o_out.width_five       = q_data.widths[4];

    // A finished segment restarts the timer
    `SPSK_ASSERT_NEXT(a_seg_restart, i_clk, i_rst_n,
        accept && (i_in.opcode == OP_TICK) && (r_tick == r_period_now),
        r_tick == '0, "timer not cleared at segment end")
    // Only ticks move the timer and the phase
    `SPSK_ASSERT_NEXT(a_timer_hold, i_clk, i_rst_n,
        !accept || (i_in.opcode != OP_TICK),
        $stable(r_tick) && $stable(r_phase), "timer moved without a tick")
    // At most one servo line high, and only during a pulse phase
    `SPSK_ASSERT_NOW(a_one_line, i_clk, i_rst_n, o_out.valid,
        $onehot0(o_out.servo_lines) &&
        ((o_out.frame_phase == PHASE_REST) == (o_out.servo_lines == '0)),
        "servo lines disagree with frame phase")

endmodule
